/* hdl/ialu_pkg.sv */
// Shared types, operation codes and helper functions for the integer ALU.
// Depends on nothing; every other file in the block imports it.
package ialu_pkg;

    localparam int XLEN   = 64;
    localparam int HALF   = 32;
    localparam int NBYTES = 8;
    localparam int CNT_W  = 7;

    typedef enum logic [4:0] {
        OP_ADDL   = 5'd0,
        OP_ADDL_V = 5'd1,
        OP_ADDQ   = 5'd2,
        OP_ADDQ_V = 5'd3,
        OP_S4ADDL = 5'd4,
        OP_S8ADDL = 5'd5,
        OP_S4ADDQ = 5'd6,
        OP_S8ADDQ = 5'd7,
        OP_CMPEQ  = 5'd8,
        OP_CMPLE  = 5'd9,
        OP_CMPLT  = 5'd10,
        OP_CMPULE = 5'd11,
        OP_CTLZ   = 5'd12,
        OP_CTTZ   = 5'd13,
        OP_MULL   = 5'd14,
        OP_MULL_V = 5'd15,
        OP_MULQ   = 5'd16,
        OP_MULQ_V = 5'd17
    } op_t;

    // Incoming instruction word, unpacked.
    typedef struct packed {
        op_t              op;
        logic [XLEN-1:0]  src_a;
        logic [XLEN-1:0]  src_b;
        logic             use_literal;
        logic [7:0]       literal_value;
    } req_t;

    // Operands, partial products and per-byte count data after the first stage.
    typedef struct packed {
        op_t                    op;
        logic [XLEN-1:0]        a;
        logic [XLEN-1:0]        b;
        logic [XLEN-1:0]        p00;
        logic [XLEN-1:0]        p01;
        logic [XLEN-1:0]        p10;
        logic [XLEN-1:0]        p11;
        logic [XLEN-1:0]        alu_res;
        logic                   alu_ov;
        logic [NBYTES-1:0]      byte_nz;
        logic [NBYTES-1:0][2:0] byte_tz;
    } s1_t;

    // Product sums and the finished non-multiply result after the second stage.
    typedef struct packed {
        op_t              op;
        logic [XLEN-1:0]  alu_res;
        logic             alu_ov;
        logic [HALF-1:0]  lo_low;
        logic [HALF+1:0]  mid;
        logic [XLEN-1:0]  hi_sum;
        logic [XLEN-1:0]  hi_corr;
        logic [HALF-1:0]  sp_hi;
    } s2_t;

    typedef struct packed {
        logic [XLEN-1:0]  result;
        logic             overflow;
    } rsp_t;

    function automatic logic [XLEN-1:0] sext32(input logic [HALF-1:0] v);
        return {{(XLEN-HALF){v[HALF-1]}}, v};
    endfunction

endpackage

/* hdl/integer_alu_add_cmp_mul_count_unit.sv */
// Top level of the integer ALU: three register stages joined by stream handshakes.
// Depends on ialu_pkg and the three stage modules.
// Each accepted word passes through the operand, merge and result stage registers.
// Throughput is one word per cycle unless the output stalls; the 64x64 multiply, split
// into four 32x32 partial products summed in stages two and three, sets the depth.
// Reset (rst_n low, asynchronous) empties every stage; the block holds no other state.
module integer_alu_add_cmp_mul_count_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // src_a [63:0], src_b [127:64], literal_value [135:128]
    input  logic [135:0] s_axis_tdata,
    // req_type [4:0], use_literal [5]
    input  logic [5:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result [63:0]
    output logic [63:0]  m_axis_tdata,
    // overflow [0]
    output logic [0:0]   m_axis_tuser
);
    import ialu_pkg::*;

    req_t req;
    s1_t  s1_data;
    s2_t  s2_data;
    rsp_t rsp;
    logic s1_valid;
    logic s1_ready;
    logic s2_valid;
    logic s2_ready;

    // Unpack the incoming word. Unused operation codes pass through and give zero.
    always_comb
    begin
        req.op            = op_t'(s_axis_tuser[4:0]);
        req.use_literal   = s_axis_tuser[5];
        req.src_a         = s_axis_tdata[63:0];
        req.src_b         = s_axis_tdata[127:64];
        req.literal_value = s_axis_tdata[135:128];
    end

    // Operand selection, partial products, add and compare, byte zero counts.
    ialu_operand_stage u_operand (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (req),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    // Partial product sums, sign corrections and the finished bit counts.
    ialu_merge_stage u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    // Multiply high half, overflow tests and the output register.
    ialu_result_stage u_result (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (rsp)
    );

    assign m_axis_tdata = rsp.result;
    assign m_axis_tuser = rsp.overflow;

endmodule

/* hdl/ialu_operand_stage.sv */
// First pipeline stage: operand B selection, the four 32x32 partial products,
// the adder and comparator results, and per-byte zero counts. Uses ialu_pkg.
module ialu_operand_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ialu_pkg::req_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ialu_pkg::s1_t  out_data
);
    import ialu_pkg::*;

    logic            valid_reg;
    s1_t             data_reg;
    s1_t             data_next;

    logic [XLEN-1:0] opa;
    logic [XLEN-1:0] opb;
    logic [XLEN-1:0] addend;
    logic [XLEN-1:0] sum;
    logic [HALF:0]   sum_l;
    logic [XLEN-1:0] cnt_vec;
    logic [7:0]      cur_byte;
    logic [2:0]      tz;

    always_comb
    begin
        opa = in_data.src_a;
        opb = in_data.use_literal ? {{(XLEN-8){1'b0}}, in_data.literal_value}
                                  : in_data.src_b;

        // Scaled adds share the one adder.
        priority if (in_data.op == OP_S4ADDL || in_data.op == OP_S4ADDQ)
            addend = {opa[XLEN-3:0], 2'b00};
        else if (in_data.op == OP_S8ADDL || in_data.op == OP_S8ADDQ)
            addend = {opa[XLEN-4:0], 3'b000};
        else
            addend = opa;
        sum   = addend + opb;
        sum_l = {opa[HALF-1], opa[HALF-1:0]} + {opb[HALF-1], opb[HALF-1:0]};

        // Leading zeros are counted as trailing zeros of the reversed word.
        for (int i = 0; i < XLEN; i++)
            cnt_vec[i] = (in_data.op == OP_CTTZ) ? opb[i] : opb[XLEN-1-i];

        data_next.op  = in_data.op;
        data_next.a   = opa;
        data_next.b   = opb;
        data_next.p00 = XLEN'(opa[HALF-1:0]) * XLEN'(opb[HALF-1:0]);
        data_next.p01 = XLEN'(opa[HALF-1:0]) * XLEN'(opb[XLEN-1:HALF]);
        data_next.p10 = XLEN'(opa[XLEN-1:HALF]) * XLEN'(opb[HALF-1:0]);
        data_next.p11 = XLEN'(opa[XLEN-1:HALF]) * XLEN'(opb[XLEN-1:HALF]);

        for (int k = 0; k < NBYTES; k++)
        begin
            cur_byte = cnt_vec[8*k +: 8];
            tz       = 3'd0;
            for (int j = 7; j >= 0; j--)
                if (cur_byte[j])
                    tz = 3'(j);
            data_next.byte_nz[k] = |cur_byte;
            data_next.byte_tz[k] = tz;
        end

        data_next.alu_res = '0;
        data_next.alu_ov  = 1'b0;
        unique case (in_data.op)
            OP_ADDL, OP_S4ADDL, OP_S8ADDL:
                data_next.alu_res = sext32(sum[HALF-1:0]);
            OP_ADDL_V:
            begin
                data_next.alu_res = sext32(sum[HALF-1:0]);
                data_next.alu_ov  = sum_l[HALF] ^ sum_l[HALF-1];
            end
            OP_ADDQ, OP_S4ADDQ, OP_S8ADDQ:
                data_next.alu_res = sum;
            OP_ADDQ_V:
            begin
                data_next.alu_res = sum;
                data_next.alu_ov  = ~(opa[XLEN-1] ^ opb[XLEN-1]) &
                                    (opa[XLEN-1] ^ sum[XLEN-1]);
            end
            OP_CMPEQ:
                data_next.alu_res = {{(XLEN-1){1'b0}}, opa == opb};
            OP_CMPLE:
                data_next.alu_res = {{(XLEN-1){1'b0}}, $signed(opa) <= $signed(opb)};
            OP_CMPLT:
                data_next.alu_res = {{(XLEN-1){1'b0}}, $signed(opa) < $signed(opb)};
            OP_CMPULE:
                data_next.alu_res = {{(XLEN-1){1'b0}}, opa <= opb};
            default:
                data_next.alu_res = '0;
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

/* hdl/ialu_merge_stage.sv */
// Second pipeline stage: sums the partial products into low, middle and high
// parts, forms the sign corrections, and finishes the zero counts. Uses ialu_pkg.
module ialu_merge_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ialu_pkg::s1_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output ialu_pkg::s2_t out_data
);
    import ialu_pkg::*;

    logic             valid_reg;
    s2_t              data_reg;
    s2_t              data_next;
    logic [CNT_W-1:0] cnt;

    always_comb
    begin
        // Lowest non-zero byte wins; an all-zero word counts as the full width.
        cnt = CNT_W'(XLEN);
        for (int k = NBYTES - 1; k >= 0; k--)
            if (in_data.byte_nz[k])
                cnt = {1'b0, 3'(k), in_data.byte_tz[k]};

        data_next.op      = in_data.op;
        data_next.alu_ov  = in_data.alu_ov;
        data_next.alu_res = (in_data.op == OP_CTLZ || in_data.op == OP_CTTZ)
                            ? XLEN'(cnt) : in_data.alu_res;

        data_next.lo_low  = in_data.p00[HALF-1:0];
        data_next.mid     = (HALF+2)'(in_data.p00[XLEN-1:HALF])
                          + (HALF+2)'(in_data.p01[HALF-1:0])
                          + (HALF+2)'(in_data.p10[HALF-1:0]);
        data_next.hi_sum  = in_data.p11
                          + XLEN'(in_data.p01[XLEN-1:HALF])
                          + XLEN'(in_data.p10[XLEN-1:HALF]);
        // Signed 128-bit high half differs from the unsigned one by these terms.
        data_next.hi_corr = (in_data.a[XLEN-1] ? in_data.b : '0)
                          + (in_data.b[XLEN-1] ? in_data.a : '0);
        // Upper half of the signed 32x32 product.
        data_next.sp_hi   = in_data.p00[XLEN-1:HALF]
                          - (in_data.a[HALF-1] ? in_data.b[HALF-1:0] : '0)
                          - (in_data.b[HALF-1] ? in_data.a[HALF-1:0] : '0);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

/* hdl/ialu_result_stage.sv */
// Third pipeline stage: completes the multiply high half, tests for overflow
// and selects the final word into the output register. Uses ialu_pkg.
module ialu_result_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  ialu_pkg::s2_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output ialu_pkg::rsp_t out_data
);
    import ialu_pkg::*;

    logic            valid_reg;
    rsp_t            data_reg;
    rsp_t            data_next;
    logic [XLEN-1:0] hi;

    always_comb
    begin
        hi = in_data.hi_sum + XLEN'(in_data.mid[HALF+1:HALF]) - in_data.hi_corr;

        unique case (in_data.op)
            OP_MULL, OP_MULL_V:
            begin
                data_next.result   = sext32(in_data.lo_low);
                data_next.overflow = (in_data.op == OP_MULL_V) &&
                                     (in_data.sp_hi != {HALF{in_data.lo_low[HALF-1]}});
            end
            OP_MULQ, OP_MULQ_V:
            begin
                data_next.result   = {in_data.mid[HALF-1:0], in_data.lo_low};
                data_next.overflow = (in_data.op == OP_MULQ_V) &&
                                     (hi != {XLEN{in_data.mid[HALF-1]}});
            end
            default:
            begin
                data_next.result   = in_data.alu_res;
                data_next.overflow = in_data.alu_ov;
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule
